[rtl/sfs_pkg.sv]
// Shared types, constants and a helper function for the sorted table Fibonacci search unit.
package sfs_pkg;

    // Field widths of the stream payloads.
    localparam int KEY_W     = 32;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 8;
    localparam int CMD_W     = 2;
    localparam int S_TDATA_W = KEY_W + DATA_W;
    localparam int M_TDATA_W = POS_W + DATA_W;
    localparam int M_TUSER_W = 2;

    // Default table depth.
    localparam int DEPTH_DEF = 128;

    // A search gives up after this many probe steps.
    localparam int PROBE_LIMIT = 64;
    localparam int PROBE_W     = $clog2(PROBE_LIMIT + 1);

    // Fibonacci numbers, enough to cover the largest supported table.
    localparam int FIB_N     = 24;
    localparam int FIB_W     = 16;
    localparam int FIB_IDX_W = $clog2(FIB_N);

    typedef logic [FIB_W-1:0] fib_t;

    localparam fib_t FIB_TABLE [FIB_N] = '{
        16'd0,    16'd1,    16'd1,    16'd2,    16'd3,    16'd5,
        16'd8,    16'd13,   16'd21,   16'd34,   16'd55,   16'd89,
        16'd144,  16'd233,  16'd377,  16'd610,  16'd987,  16'd1597,
        16'd2584, 16'd4181, 16'd6765, 16'd10946, 16'd17711, 16'd28657
    };

    // Command codes carried in the input tuser.
    typedef enum logic [CMD_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SORT   = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SORT_RD_I,
        ST_SORT_LD_I,
        ST_SORT_RD_J,
        ST_SORT_CMP,
        ST_SORT_WR_I,
        ST_SRCH_INIT,
        ST_SRCH_RD0,
        ST_SRCH_ADJ,
        ST_SRCH_PROBE,
        ST_SRCH_CMP,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic insert;
        logic sort_rd_i;
        logic sort_ld_i;
        logic sort_rd_j;
        logic sort_cmp;
        logic sort_wr_i;
        logic srch_init;
        logic srch_rd;
        logic srch_adj;
        logic srch_step;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic i_done;
        logic j_done;
        logic p_out;
        logic probe_end;
        logic key_eq;
        logic key_lt;
        logic r_zero;
        logic q_one;
    } dp_stat_t;

    // Fibonacci number at an index; indices outside the table count as zero.
    function automatic fib_t fib_at(input int idx);
        fib_t value;
        value = '0;
        if (idx >= 0 && idx < FIB_N)
        begin
            value = FIB_TABLE[idx[FIB_IDX_W-1:0]];
        end
        return value;
    endfunction

endpackage

[rtl/sorted_table_fibonacci_search_unit.sv]
// Top level of the sorted record table with insert, exchange sort and Fibonacci search.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------------------
//  s_*     | in        | s_tvalid, s_tready | tuser: command; tdata: key, data
//  m_*     | out       | m_tvalid, m_tready | tuser: found, table_full; tdata: position, data
//
// An insert writes one record; a search reads the key and data memories once per compared
// probe, about log-phi of the count probes in all, and ends early when a probe leaves the
// table. Sort does one exchange compare at a time through the single memory read port.
// Reset clears the record count; the record stores are not cleared, as only written
// positions are ever read. A finished result waits in the output register, and the next
// command is taken while it waits.
module sorted_table_fibonacci_search_unit #(
    parameter int DEPTH = sfs_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sfs_pkg::S_TDATA_W-1:0] s_tdata,  // key [31:0], data [63:32]
    input  logic [sfs_pkg::CMD_W-1:0]     s_tuser,  // command [1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sfs_pkg::M_TDATA_W-1:0] m_tdata,  // position [7:0], found_data [39:8]
    output logic [sfs_pkg::M_TUSER_W-1:0] m_tuser   // found [0], table_full [1]
);

    sfs_pkg::dp_cmd_t  cmd;
    sfs_pkg::dp_stat_t stat;

    sfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sfs_datapath #(.DEPTH(DEPTH)) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

[rtl/sfs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module sfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/sfs_datapath.sv]
// Datapath: record stores, record count, sort and search registers, result register.
module sfs_datapath #(
    parameter int DEPTH = sfs_pkg::DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [sfs_pkg::S_TDATA_W-1:0]   s_tdata,
    input  sfs_pkg::dp_cmd_t                cmd,
    output sfs_pkg::dp_stat_t               stat,
    output logic [sfs_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [sfs_pkg::M_TUSER_W-1:0]   m_tuser
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int PW = CW + 2;
    localparam int KW = sfs_pkg::KEY_W;
    localparam int DW = sfs_pkg::DATA_W;
    localparam int FW = sfs_pkg::FIB_W;
    localparam int IW = sfs_pkg::FIB_IDX_W;
    localparam int RW = sfs_pkg::PROBE_W;

    // Control state, cleared by reset.
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] fidx_reg, fidx_next;

    // Payload state.
    logic signed [KW-1:0]   key_reg, key_next;
    logic signed [DW-1:0]   data_reg, data_next;
    logic [CW-1:0]          i_reg, i_next;
    logic [CW:0]            j_reg, j_next;
    logic signed [KW-1:0]   hold_key_reg, hold_key_next;
    logic signed [DW-1:0]   hold_data_reg, hold_data_next;
    logic signed [PW-1:0]   p_reg, p_next;
    logic signed [PW-1:0]   q_reg, q_next;
    logic signed [PW-1:0]   r_reg, r_next;
    logic [RW-1:0]          probe_reg, probe_next;
    logic                   res_found_reg, res_found_next;
    logic                   res_full_reg, res_full_next;
    logic [sfs_pkg::POS_W-1:0] res_pos_reg, res_pos_next;
    logic signed [DW-1:0]   res_data_reg, res_data_next;
    logic [sfs_pkg::M_TDATA_W-1:0] out_tdata_reg, out_tdata_next;
    logic [sfs_pkg::M_TUSER_W-1:0] out_tuser_reg, out_tuser_next;

    // Memory port signals.
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [KW-1:0] wr_key;
    logic [DW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [KW-1:0] rd_key_raw;
    logic [DW-1:0] rd_data_raw;
    logic signed [KW-1:0] rd_key;
    logic signed [DW-1:0] rd_data;

    // Fibonacci terms around the current index and derived values.
    sfs_pkg::fib_t fib_k, fib_top, fib_p0, fib_q0, fib_r0;
    logic signed [PW-1:0] n_s;
    logic signed [PW-1:0] top_s;
    logic [FW:0] cnt_plus;

    sfs_ram #(.WIDTH(KW), .DEPTH(DEPTH)) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_key),
        .rd_addr (rd_addr),
        .rd_data (rd_key_raw)
    );

    sfs_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_data_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data_raw)
    );

    assign rd_key  = $signed(rd_key_raw);
    assign rd_data = $signed(rd_data_raw);

    // Fibonacci lookups: fidx_reg steps up when a new count equals its term.
    always_comb
    begin
        fib_k    = sfs_pkg::fib_at(int'(fidx_reg));
        fib_top  = sfs_pkg::fib_at(int'(fidx_reg) - 1);
        fib_p0   = sfs_pkg::fib_at(int'(fidx_reg) - 2);
        fib_q0   = sfs_pkg::fib_at(int'(fidx_reg) - 3);
        fib_r0   = sfs_pkg::fib_at(int'(fidx_reg) - 4);
        n_s      = $signed(PW'(count_reg));
        top_s    = $signed(PW'(fib_top));
        cnt_plus = (FW+1)'(count_reg) + (FW+1)'(1);
    end

    // Status toward the controller.
    always_comb
    begin
        stat.empty     = (count_reg == '0);
        stat.i_done    = (i_reg >= count_reg);
        stat.j_done    = (j_reg > (CW+1)'(count_reg));
        stat.p_out     = (p_reg < $signed(PW'(1))) || (p_reg > n_s);
        stat.probe_end = (probe_reg == RW'(sfs_pkg::PROBE_LIMIT));
        stat.key_eq    = (key_reg == rd_key);
        stat.key_lt    = (key_reg < rd_key);
        stat.r_zero    = (r_reg == '0);
        stat.q_one     = (q_reg == $signed(PW'(1)));
    end

    // Next-state logic for all datapath registers and memory ports.
    always_comb
    begin
        count_next     = count_reg;
        fidx_next      = fidx_reg;
        key_next       = key_reg;
        data_next      = data_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        hold_key_next  = hold_key_reg;
        hold_data_next = hold_data_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        probe_next     = probe_reg;
        res_found_next = res_found_reg;
        res_full_next  = res_full_reg;
        res_pos_next   = res_pos_reg;
        res_data_next  = res_data_reg;
        out_tdata_next = out_tdata_reg;
        out_tuser_next = out_tuser_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_key         = key_reg;
        wr_data        = data_reg;
        rd_addr        = '0;

        // Capture a new item and clear the pending result.
        if (cmd.load_in)
        begin
            key_next       = $signed(s_tdata[KW-1:0]);
            data_next      = $signed(s_tdata[KW+DW-1:KW]);
            res_found_next = 1'b0;
            res_full_next  = 1'b0;
            res_pos_next   = '0;
            res_data_next  = '0;
            i_next         = CW'(1);
        end

        // Append a record, or flag a full table.
        if (cmd.insert)
        begin
            if (count_reg == CW'(DEPTH))
            begin
                res_full_next = 1'b1;
            end
            else
            begin
                wr_en      = 1'b1;
                wr_addr    = AW'(count_reg);
                count_next = count_reg + CW'(1);
                if ((FW+1)'(fib_k) == cnt_plus)
                begin
                    fidx_next = fidx_reg + IW'(1);
                end
            end
        end

        // Exchange sort: outer record is kept in the hold registers.
        if (cmd.sort_rd_i)
        begin
            rd_addr = AW'(i_reg - CW'(1));
        end
        if (cmd.sort_ld_i)
        begin
            hold_key_next  = rd_key;
            hold_data_next = rd_data;
            j_next         = (CW+1)'(i_reg) + (CW+1)'(1);
        end
        if (cmd.sort_rd_j)
        begin
            rd_addr = AW'(j_reg - (CW+1)'(1));
        end
        if (cmd.sort_cmp)
        begin
            if (hold_key_reg > rd_key)
            begin
                wr_en          = 1'b1;
                wr_addr        = AW'(j_reg - (CW+1)'(1));
                wr_key         = hold_key_reg;
                wr_data        = hold_data_reg;
                hold_key_next  = rd_key;
                hold_data_next = rd_data;
            end
            j_next = j_reg + (CW+1)'(1);
        end
        if (cmd.sort_wr_i)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(i_reg - CW'(1));
            wr_key  = hold_key_reg;
            wr_data = hold_data_reg;
            i_next  = i_reg + CW'(1);
        end

        // Fibonacci search.
        if (cmd.srch_init)
        begin
            p_next     = $signed(PW'(fib_p0));
            q_next     = $signed(PW'(fib_q0));
            r_next     = $signed(PW'(fib_r0));
            probe_next = '0;
        end
        if (cmd.srch_rd)
        begin
            rd_addr = AW'($unsigned(p_reg - $signed(PW'(1))));
        end
        if (cmd.srch_adj)
        begin
            if (key_reg > rd_key)
            begin
                p_next = p_reg + n_s - top_s + $signed(PW'(1));
            end
        end
        if (cmd.srch_step)
        begin
            probe_next = probe_reg + RW'(1);
            if (stat.key_eq)
            begin
                res_found_next = 1'b1;
                res_pos_next   = sfs_pkg::POS_W'($unsigned(p_reg));
                res_data_next  = rd_data;
            end
            else if (stat.key_lt)
            begin
                p_next = p_reg - r_reg;
                q_next = r_reg;
                r_next = q_reg - r_reg;
            end
            else
            begin
                p_next = p_reg + r_reg;
                q_next = q_reg - r_reg;
                r_next = r_reg - (q_reg - r_reg);
            end
        end

        // Move the finished result into the output register.
        if (cmd.out_load)
        begin
            out_tdata_next = {res_data_reg, res_pos_reg};
            out_tuser_next = {res_full_reg, res_found_reg};
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fidx_reg  <= IW'(2);
        end
        else
        begin
            count_reg <= count_next;
            fidx_reg  <= fidx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        data_reg      <= data_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        hold_key_reg  <= hold_key_next;
        hold_data_reg <= hold_data_next;
        p_reg         <= p_next;
        q_reg         <= q_next;
        r_reg         <= r_next;
        probe_reg     <= probe_next;
        res_found_reg <= res_found_next;
        res_full_reg  <= res_full_next;
        res_pos_reg   <= res_pos_next;
        res_data_reg  <= res_data_next;
        out_tdata_reg <= out_tdata_next;
        out_tuser_reg <= out_tuser_next;
    end

    assign m_tdata = out_tdata_reg;
    assign m_tuser = out_tuser_reg;

endmodule

[rtl/sfs_ctrl.sv]
// Controller: sequences insert, sort and search steps and owns both handshakes.
module sfs_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [sfs_pkg::CMD_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    input  sfs_pkg::dp_stat_t         stat,
    output sfs_pkg::dp_cmd_t          cmd
);

    sfs_pkg::state_t state_reg, state_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == sfs_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfs_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (sfs_pkg::op_t'(s_tuser))
                        sfs_pkg::OP_INSERT: state_next = sfs_pkg::ST_INSERT;
                        sfs_pkg::OP_SORT:   state_next = sfs_pkg::ST_SORT_RD_I;
                        sfs_pkg::OP_SEARCH: state_next = sfs_pkg::ST_SRCH_INIT;
                        default:            state_next = sfs_pkg::ST_FINISH;
                    endcase
                end
            end
            sfs_pkg::ST_INSERT:    state_next = sfs_pkg::ST_FINISH;
            sfs_pkg::ST_SORT_RD_I:
            begin
                state_next = stat.i_done ? sfs_pkg::ST_FINISH : sfs_pkg::ST_SORT_LD_I;
            end
            sfs_pkg::ST_SORT_LD_I: state_next = sfs_pkg::ST_SORT_RD_J;
            sfs_pkg::ST_SORT_RD_J:
            begin
                state_next = stat.j_done ? sfs_pkg::ST_SORT_WR_I : sfs_pkg::ST_SORT_CMP;
            end
            sfs_pkg::ST_SORT_CMP:  state_next = sfs_pkg::ST_SORT_RD_J;
            sfs_pkg::ST_SORT_WR_I: state_next = sfs_pkg::ST_SORT_RD_I;
            sfs_pkg::ST_SRCH_INIT:
            begin
                state_next = stat.empty ? sfs_pkg::ST_FINISH : sfs_pkg::ST_SRCH_RD0;
            end
            sfs_pkg::ST_SRCH_RD0:
            begin
                state_next = stat.p_out ? sfs_pkg::ST_FINISH : sfs_pkg::ST_SRCH_ADJ;
            end
            sfs_pkg::ST_SRCH_ADJ:  state_next = sfs_pkg::ST_SRCH_PROBE;
            sfs_pkg::ST_SRCH_PROBE:
            begin
                if (stat.probe_end || stat.p_out)
                begin
                    state_next = sfs_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = sfs_pkg::ST_SRCH_CMP;
                end
            end
            sfs_pkg::ST_SRCH_CMP:
            begin
                // A hit, or a step that would leave the Fibonacci range, ends the search.
                if (stat.key_eq || (stat.key_lt && stat.r_zero) ||
                    (!stat.key_lt && stat.q_one))
                begin
                    state_next = sfs_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = sfs_pkg::ST_SRCH_PROBE;
                end
            end
            sfs_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = sfs_pkg::ST_IDLE;
                end
            end
            default: state_next = sfs_pkg::ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            sfs_pkg::ST_IDLE:       cmd.load_in   = s_tvalid;
            sfs_pkg::ST_INSERT:     cmd.insert    = 1'b1;
            sfs_pkg::ST_SORT_RD_I:  cmd.sort_rd_i = !stat.i_done;
            sfs_pkg::ST_SORT_LD_I:  cmd.sort_ld_i = 1'b1;
            sfs_pkg::ST_SORT_RD_J:  cmd.sort_rd_j = !stat.j_done;
            sfs_pkg::ST_SORT_CMP:   cmd.sort_cmp  = 1'b1;
            sfs_pkg::ST_SORT_WR_I:  cmd.sort_wr_i = 1'b1;
            sfs_pkg::ST_SRCH_INIT:  cmd.srch_init = 1'b1;
            sfs_pkg::ST_SRCH_RD0:   cmd.srch_rd   = !stat.p_out;
            sfs_pkg::ST_SRCH_ADJ:   cmd.srch_adj  = 1'b1;
            sfs_pkg::ST_SRCH_PROBE: cmd.srch_rd   = !(stat.probe_end || stat.p_out);
            sfs_pkg::ST_SRCH_CMP:   cmd.srch_step = 1'b1;
            sfs_pkg::ST_FINISH:     cmd.out_load  = out_free;
            default:                cmd = '0;
        endcase
    end

    // Output valid holds until the result transfer completes.
    always_comb
    begin
        m_tvalid_next = cmd.out_load || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sfs_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

[rtl/sfs_checker.sv]
// Port-level checker for the sorted table Fibonacci search unit, with its bind.
module sfs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sfs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [sfs_pkg::M_TUSER_W-1:0] m_tuser
);

    // The unit works on one command at a time after taking a transfer.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a command is still in work");

    // A stalled result stays put.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // A rejected insert never reports a hit or any data.
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && m_tdata == '0))
        else $error("table full result carries search fields");

    // Without a hit, position and data are zero.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("miss result carries nonzero fields");

    // A new result only appears at the end of a command in work.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while the unit was idle");

endmodule

bind sorted_table_fibonacci_search_unit sfs_checker u_sfs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[dv/sorted_table_fibonacci_search_unit_test.sv]
// Self-checking stream testbench for the sorted table Fibonacci search unit.
`timescale 1ns / 100ps

module sorted_table_fibonacci_search_unit_test;

    localparam int TABLE_DEPTH  = sfs_pkg::DEPTH_DEF;
    localparam int PROBE_CAP    = 64;
    localparam int RANDOM_ITEMS = 1250;
    localparam int SORT_BUDGET  = 24;
    localparam int TAIL_CYCLES  = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int REPORT_MAX   = 10;

    typedef logic signed [31:0] word_t;

    // One command as offered on the input stream.
    typedef struct {
        sfs_pkg::op_t cmd;
        word_t        key;
        word_t        dat;
        bit           drain_first;
    } command_t;

    // One result as carried on the output stream.
    typedef struct packed {
        logic        found;
        logic [7:0]  position;
        logic [31:0] found_data;
        logic        table_full;
    } lookup_result_t;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [sfs_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [sfs_pkg::CMD_W-1:0]     s_tuser  = sfs_pkg::OP_NOP;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [sfs_pkg::M_TDATA_W-1:0] m_tdata;
    logic [sfs_pkg::M_TUSER_W-1:0] m_tuser;

    sorted_table_fibonacci_search_unit #(
        .DEPTH(TABLE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Shadow copy of the record table.
    word_t rec_key  [1:TABLE_DEPTH];
    word_t rec_data [1:TABLE_DEPTH];
    int    rec_count = 0;

    // Stimulus and scoreboard storage.
    command_t       cmd_queue[$];
    lookup_result_t due_results[$];
    word_t          gen_keys[$];
    int             gen_count    = 0;
    int             total_cmds   = 0;
    int             cmds_sent    = 0;
    int             results_seen = 0;
    int             mismatches   = 0;
    int             cycles       = 0;
    int             hold_left    = 0;
    int             holds_done   = 0;
    int             n_insert     = 0;
    int             n_reject     = 0;
    int             n_sort       = 0;
    int             n_search     = 0;
    int             n_hit        = 0;
    int             n_nop        = 0;

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Fibonacci number by index; negative indices count as zero.
    function automatic longint fib_num(input int idx);
        longint a;
        longint b;
        longint t;
        int     i;
        a = 0;
        b = 1;
        if (idx < 0)
            return 0;
        for (i = 0; i < idx; i++)
        begin
            t = a + b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // Fibonacci search with offset over positions 1..rec_count; 0 means no hit.
    function automatic int fib_probe_search(input word_t want);
        longint n;
        longint p;
        longint q;
        longint r;
        longint t;
        int     top;
        int     k;
        int     probes;
        n = rec_count;
        if (n == 0)
            return 0;
        top = 1;
        k = 2;
        while (k < 64 && fib_num(k) <= n)
            k++;
        if (k < 64)
            top = k - 1;
        p = fib_num(top - 1);
        q = fib_num(top - 2);
        r = fib_num(top - 3);
        if (p < 1 || p > n)
            return 0;
        if (want > rec_key[p])
            p = p + n - fib_num(top) + 1;
        for (probes = 0; probes < PROBE_CAP; probes++)
        begin
            if (p < 1 || p > n)
                return 0;
            if (want == rec_key[p])
                return int'(p);
            if (want < rec_key[p])
            begin
                if (r == 0)
                    return 0;
                p = p - r;
                t = q;
                q = r;
                r = t - r;
            end
            else
            begin
                if (q == 1)
                    return 0;
                p = p + r;
                q = q - r;
                r = r - q;
            end
        end
        return 0;
    endfunction

    // Applies one accepted command to the shadow table and forms its result.
    task automatic apply_to_table(input command_t c, output lookup_result_t res);
        int    hit;
        int    i;
        int    j;
        word_t tk;
        word_t td;
        res = '0;
        case (c.cmd)
            sfs_pkg::OP_INSERT:
            begin
                n_insert++;
                if (rec_count >= TABLE_DEPTH)
                begin
                    res.table_full = 1'b1;
                    n_reject++;
                end
                else
                begin
                    rec_count++;
                    rec_key[rec_count]  = c.key;
                    rec_data[rec_count] = c.dat;
                end
            end
            sfs_pkg::OP_SORT:
            begin
                n_sort++;
                for (i = 1; i < rec_count; i++)
                begin
                    for (j = i + 1; j <= rec_count; j++)
                    begin
                        if (rec_key[i] > rec_key[j])
                        begin
                            tk = rec_key[i];
                            td = rec_data[i];
                            rec_key[i]  = rec_key[j];
                            rec_data[i] = rec_data[j];
                            rec_key[j]  = tk;
                            rec_data[j] = td;
                        end
                    end
                end
            end
            sfs_pkg::OP_SEARCH:
            begin
                n_search++;
                hit = fib_probe_search(c.key);
                if (hit != 0)
                begin
                    res.found      = 1'b1;
                    res.position   = hit[7:0];
                    res.found_data = rec_data[hit];
                    n_hit++;
                end
            end
            default:
            begin
                n_nop++;
            end
        endcase
    endtask

    // Queues one command and tracks which keys the table will hold.
    task automatic add_cmd(input sfs_pkg::op_t cmd, input word_t key, input word_t dat,
                           input bit drain_first);
        command_t c;
        c.cmd         = cmd;
        c.key         = key;
        c.dat         = dat;
        c.drain_first = drain_first;
        cmd_queue.push_back(c);
        if (cmd == sfs_pkg::OP_INSERT && gen_count < TABLE_DEPTH)
        begin
            gen_count++;
            gen_keys.push_back(key);
        end
    endtask

    // Key mix: extremes, a narrow band that yields duplicates, and full-range values.
    function automatic word_t pick_key();
        word_t k;
        case ($urandom_range(0, 9))
            0:       k = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1, 2, 3:
            begin
                k = $urandom_range(0, 16);
                k = k - 8;
            end
            default: k = $urandom;
        endcase
        return k;
    endfunction

    // Idle percent per side; swapped in the second third, zero in the last third.
    function automatic int idle_pct(input bit receiver, input int sent);
        if (sent < total_cmds / 3)
            return receiver ? 82 : 37;
        else if (sent < 2 * total_cmds / 3)
            return receiver ? 37 : 82;
        return 0;
    endfunction

    // Input driver: predicts on each transfer, then offers the next command.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        command_t       taken;
        command_t       next_cmd;
        lookup_result_t due;
        bit             holding;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= sfs_pkg::OP_NOP;
        end
        else
        begin
            holding = s_tvalid && !s_tready;
            if (s_tvalid && s_tready)
            begin
                taken.cmd         = sfs_pkg::op_t'(s_tuser);
                taken.key         = s_tdata[31:0];
                taken.dat         = s_tdata[63:32];
                taken.drain_first = 1'b0;
                apply_to_table(taken, due);
                due_results.push_back(due);
                cmds_sent <= cmds_sent + 1;
            end
            if (!holding)
            begin
                if (cmd_queue.size() != 0
                    && !(cmd_queue[0].drain_first && due_results.size() != 0)
                    && $urandom_range(0, 99) >= idle_pct(1'b0, cmds_sent))
                begin
                    next_cmd = cmd_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_cmd.dat, next_cmd.key};
                    s_tuser  <= next_cmd.cmd;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compares each result transfer with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        lookup_result_t got;
        lookup_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.found      = m_tuser[0];
                got.table_full = m_tuser[1];
                got.position   = m_tdata[7:0];
                got.found_data = m_tdata[39:8];
                results_seen <= results_seen + 1;
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result with none outstanding:", $realtime,
                                 " found=%0b pos=%0d data=%h full=%0b",
                                 got.found, got.position, got.found_data,
                                 got.table_full);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("%0t: result %0d mismatch", $realtime, results_seen);
                            $display("    expected found=%0b pos=%0d data=%h full=%0b",
                                     want.found, want.position, want.found_data,
                                     want.table_full);
                            $display("    actual   found=%0b pos=%0d data=%h full=%0b",
                                     got.found, got.position, got.found_data,
                                     got.table_full);
                        end
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(1'b1, cmds_sent));
        end
    end

    // Long receiver hold-offs so the block backs up and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            holds_done <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if ((holds_done == 0 && results_seen >= 150)
                 || (holds_done == 1 && results_seen >= 700))
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, due_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus generation, reset, and end of run.
    initial
    begin : stimulus
        int    target;
        int    burst;
        int    i;
        int    sorts_left;
        bit    drain;
        word_t probe;
        sfs_pkg::op_t op;

        // Empty table, then a single record, then the key and data extremes.
        add_cmd(sfs_pkg::OP_SEARCH, 32'sd0, 32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_SORT, 32'sd0, 32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_cmd(sfs_pkg::OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_cmd(sfs_pkg::OP_SEARCH, 32'h8000_0000, 32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_SEARCH, 32'h7FFF_FFFF, 32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_SORT, 32'sd0, 32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        add_cmd(sfs_pkg::OP_INSERT, 32'sd0, 32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_cmd(sfs_pkg::OP_INSERT, 32'sd5, 32'h5A5A_5A5A, 1'b0);
        add_cmd(sfs_pkg::OP_SEARCH, 32'sd0, 32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_SORT, 32'sd0, 32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_SEARCH, 32'h8000_0000, 32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_SEARCH, 32'h7FFF_FFFF, 32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_SEARCH, 32'sd5, 32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_SEARCH, 32'sd4, 32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_SEARCH, 32'sd6, 32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_INSERT, 32'sd5, 32'hA5A5_A5A5, 1'b0);
        add_cmd(sfs_pkg::OP_SORT, 32'sd0, 32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_SEARCH, 32'sd5, 32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_NOP, 32'sd0, 32'sd0, 1'b0);

        // Random part: mostly insert bursts, an occasional sort and runs of lookups.
        target     = cmd_queue.size() + RANDOM_ITEMS;
        sorts_left = SORT_BUDGET;
        drain      = 1'b1;
        while (cmd_queue.size() < target)
        begin
            if ($urandom_range(0, 39) == 0)
                drain = 1'b1;
            if ($urandom_range(0, 99) < 75)
            begin
                burst = $urandom_range(0, 3);
                for (i = 0; i < burst; i++)
                begin
                    add_cmd(sfs_pkg::OP_INSERT, pick_key(), $urandom, drain);
                    drain = 1'b0;
                end
                if (sorts_left > 0 && $urandom_range(0, 5) == 0)
                begin
                    add_cmd(sfs_pkg::OP_SORT, $urandom, $urandom, drain);
                    drain = 1'b0;
                    sorts_left--;
                end
                burst = $urandom_range(3, 10);
                for (i = 0; i < burst; i++)
                begin
                    if (gen_keys.size() != 0 && $urandom_range(0, 3) != 0)
                        probe = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
                    else if (gen_keys.size() != 0 && $urandom_range(0, 1) == 0)
                        probe = gen_keys[$urandom_range(0, gen_keys.size() - 1)]
                                + ($urandom_range(0, 1) ? 1 : -1);
                    else
                        probe = pick_key();
                    add_cmd(sfs_pkg::OP_SEARCH, probe, $urandom, drain);
                    drain = 1'b0;
                end
            end
            else
            begin
                burst = $urandom_range(1, 4);
                for (i = 0; i < burst; i++)
                begin
                    op = sfs_pkg::op_t'($urandom_range(0, 3));
                    if (op == sfs_pkg::OP_SORT)
                    begin
                        if (sorts_left == 0)
                            op = sfs_pkg::OP_NOP;
                        else
                            sorts_left--;
                    end
                    add_cmd(op, $urandom, $urandom, drain);
                    drain = 1'b0;
                end
            end
        end

        // Make sure the table ends full: a refused insert, a full sort and lookups.
        while (gen_count < TABLE_DEPTH)
            add_cmd(sfs_pkg::OP_INSERT, pick_key(), $urandom, 1'b0);
        add_cmd(sfs_pkg::OP_INSERT, pick_key(), $urandom, 1'b0);
        add_cmd(sfs_pkg::OP_SORT, 32'sd0, 32'sd0, 1'b0);
        for (i = 0; i < 8; i++)
            add_cmd(sfs_pkg::OP_SEARCH, gen_keys[$urandom_range(0, gen_keys.size() - 1)],
                    32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_SEARCH, 32'h7FFF_FFFF, 32'sd0, 1'b0);
        add_cmd(sfs_pkg::OP_SEARCH, 32'h8000_0000, 32'sd0, 1'b0);
        total_cmds = cmd_queue.size();

        // Reset, then run until every command has been sent and answered.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (results_seen < total_cmds)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d commands: %0d inserts (%0d refused on a full table), %0d sorts,",
                 cmds_sent, n_insert, n_reject, n_sort);
        $display("%0d searches (%0d hits), %0d no-ops; %0d results checked, %0d mismatches.",
                 n_search, n_hit, n_nop, results_seen, mismatches);
        if (mismatches == 0 && due_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sorted_table_fibonacci_search_unit.f]
rtl/sfs_pkg.sv
rtl/sfs_ram.sv
rtl/sfs_datapath.sv
rtl/sfs_ctrl.sv
rtl/sorted_table_fibonacci_search_unit.sv
rtl/sfs_checker.sv
dv/sorted_table_fibonacci_search_unit_test.sv
